// ===== rtl/core/hsl_saturation_adjust_unit_defines.svh =====
// Assertion macros for the HSL saturation adjust unit.
// Used by the port checker; no other dependencies.
`ifndef HSL_SATURATION_ADJUST_UNIT_DEFINES_SVH
`define HSL_SATURATION_ADJUST_UNIT_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define HSA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hsa_pkg.sv =====
// Shared constants and types for the HSL saturation adjust unit.
// No dependencies.
`default_nettype none

package hsa_pkg;

    localparam int CHANNEL_BITS = 8;

    localparam int Q_W = 17;

    localparam logic [16:0] ONE_Q        = 17'd65536;
    localparam logic [16:0] HALF_Q       = 17'd32768;
    localparam logic [16:0] THIRD_Q      = 17'd21845;
    localparam logic [16:0] SIXTH_Q      = 17'd10922;
    localparam logic [16:0] TWO_THIRDS_Q = 17'd43690;

    localparam logic [9:0] GAIN_UNITY = 10'd256;
    localparam logic [8:0] GAIN_SPAN  = 9'd256;

    // ceil(2^30 / 360): deg * DEG_RECIP >> 14 gives floor(deg * 65536 / 360) for deg < 360
    localparam logic [21:0] DEG_RECIP = 22'd2982617;

    localparam logic [9:0] GAIN_RESET = 10'd256;
    localparam logic [7:0] FS_RESET   = 8'd255;

    typedef enum logic {
        CFG_GAIN = 1'b0,
        CFG_FULL = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        RG_RISE = 4'b0001,
        RG_TOP  = 4'b0010,
        RG_FALL = 4'b0100,
        RG_LOW  = 4'b1000
    } region_t;

endpackage

`default_nettype wire

// ===== rtl/core/hsa_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// No dependencies.
`default_nettype none

module hsa_div #(
    parameter int NUM_W  = 24,
    parameter int DEN_W  = 8,
    parameter int Q_W    = 17,
    parameter int SIDE_W = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              ce,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SIDE_W-1:0] side,
    output logic                   out_valid,
    output logic [Q_W-1:0]         quot,
    output logic [SIDE_W-1:0]      side_out
);

    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [NUM_W-1:0]  w_reg    [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];
    logic              vld_reg  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_step
        logic [DEN_W-1:0]  rem_in;
        logic [NUM_W-1:0]  w_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign w_in    = num;
            assign den_in  = den;
            assign side_in = side;
            assign vld_in  = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign w_in    = w_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        assign trial = {rem_in, w_in[NUM_W-1]};
        assign ge    = trial >= {1'b0, den_in};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ce) begin
                vld_reg[k]  <= vld_in;
                rem_reg[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                w_reg[k]    <= {w_in[NUM_W-2:0], ge};
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign quot      = w_reg[NUM_W-1][Q_W-1:0];
    assign side_out  = side_reg[NUM_W-1];

endmodule

`default_nettype wire

// ===== rtl/core/hsl_saturation_adjust_unit.sv =====
// One pixel per cycle sustained, as long as no result waits on m_tready.
// The whole pipeline advances together; it holds only while a result waits on m_tready.
// Depth is set by the four bit-serial divider pipelines in series (normalise,
// saturation/hue, gain scaling, back-conversion). Reset (synchronous, active low)
// empties the pipeline and sets saturation_gain to 256 and full_scale to 255.
`default_nettype none

module hsl_saturation_adjust_unit (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic                                          cfg_we,
    input  wire logic                                          cfg_addr,
    input  wire logic [9:0]                                    cfg_wdata,
    input  wire logic                                          s_tvalid,
    output logic                                               s_tready,
    // in_red, in_green, in_blue from bit 0 up, zero padded
    input  wire logic [((3*hsa_pkg::CHANNEL_BITS+7)/8)*8-1:0]  s_tdata,
    output logic                                               m_tvalid,
    input  wire logic                                          m_tready,
    // out_red, out_green, out_blue from bit 0 up
    output logic [23:0]                                        m_tdata
);

    localparam int CB = hsa_pkg::CHANNEL_BITS;

    logic [9:0] gain_reg;
    logic [7:0] fs_reg;
    logic [7:0] fsz;
    logic       ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= hsa_pkg::GAIN_RESET;
            fs_reg   <= hsa_pkg::FS_RESET;
        end else if (cfg_we) begin
            case (hsa_pkg::cfg_idx_t'(cfg_addr))
                hsa_pkg::CFG_GAIN: gain_reg <= cfg_wdata;
                hsa_pkg::CFG_FULL: fs_reg   <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign fsz      = (fs_reg == 8'd0) ? 8'd1 : fs_reg;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // ---- clamp to full scale; gray is judged on the clamped levels
    logic [7:0] ch_c   [3];
    logic [7:0] ch_reg [3];
    logic       gray_reg;
    logic       v_a_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (s_tdata[i*CB +: CB] > fsz)
                ch_c[i] = fsz;
            else
                ch_c[i] = s_tdata[i*CB +: CB];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_a_reg <= 1'b0;
        end else if (ce) begin
            v_a_reg <= s_tvalid;
            for (int i = 0; i < 3; i++)
                ch_reg[i] <= ch_c[i];
            gray_reg <= (ch_c[0] == ch_c[1]) && (ch_c[1] == ch_c[2]);
        end
    end

    // ---- normalise: n = ch * 65536 / fs
    logic [16:0] nv [3];
    logic        v_n;
    logic        gray_n;
    logic [2:0]  n_vld;
    logic [2:0]  n_gray;

    for (genvar i = 0; i < 3; i++) begin : g_norm
        hsa_div #(.NUM_W(24), .DEN_W(8), .Q_W(17), .SIDE_W(1)) u_div (
            .aclk(aclk), .aresetn(aresetn), .ce(ce), .in_valid(v_a_reg),
            .num({ch_reg[i], 16'd0}), .den(fsz), .side(gray_reg),
            .out_valid(n_vld[i]),
            .quot(nv[i]), .side_out(n_gray[i])
        );
    end
    assign v_n    = &n_vld;
    assign gray_n = &n_gray;

    // ---- max, min, hue term
    logic [16:0]        mx, mn;
    logic               rmax, gmax;
    logic [16:0]        delta_reg;
    logic [17:0]        sum_reg;
    logic [16:0]        l_b_reg;
    logic signed [20:0] diff_reg;
    logic               gray_b_reg;
    logic               v_b_reg;

    always_comb begin
        mx = nv[0];
        mn = nv[0];
        for (int i = 1; i < 3; i++) begin
            if (nv[i] > mx) mx = nv[i];
            if (nv[i] < mn) mn = nv[i];
        end
        rmax = nv[0] == mx;
        gmax = nv[1] == mx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_b_reg <= 1'b0;
        end else if (ce) begin
            v_b_reg    <= v_n;
            delta_reg  <= mx - mn;
            sum_reg    <= {1'b0, mx} + {1'b0, mn};
            gray_b_reg <= gray_n;
            if (gray_n)
                l_b_reg <= nv[0];
            else
                l_b_reg <= 17'(({1'b0, mx} + {1'b0, mn}) >> 1);
            if (rmax)
                diff_reg <= $signed({4'b0, nv[1]}) - $signed({4'b0, nv[2]});
            else if (gmax)
                diff_reg <= $signed({3'b0, mx - mn, 1'b0})
                          + $signed({4'b0, nv[2]}) - $signed({4'b0, nv[0]});
            else
                diff_reg <= $signed({2'b0, mx - mn, 2'b0})
                          + $signed({4'b0, nv[0]}) - $signed({4'b0, nv[1]});
        end
    end

    // ---- divider operands
    logic signed [27:0] t_raw;
    logic signed [27:0] t_fix;
    logic [32:0]        s_num_reg;
    logic [17:0]        s_den_reg;
    logic [32:0]        h_num_reg;
    logic [16:0]        h_den_reg;
    logic [16:0]        l_c_reg;
    logic               v_c_reg;

    assign t_raw = 28'(diff_reg) * 28'sd60;
    assign t_fix = (t_raw < 0) ? t_raw + $signed({2'b0, 26'(delta_reg * 26'd360)}) : t_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_c_reg <= 1'b0;
        end else if (ce) begin
            v_c_reg <= v_b_reg;
            l_c_reg <= l_b_reg;
            if (gray_b_reg) begin
                s_num_reg <= '0;
                s_den_reg <= 18'd1;
                h_num_reg <= '0;
                h_den_reg <= 17'd1;
            end else begin
                s_num_reg <= {delta_reg, 16'd0};
                s_den_reg <= (l_b_reg < hsa_pkg::HALF_Q) ? sum_reg
                           : 18'(18'd131072 - sum_reg);
                h_num_reg <= {8'd0, t_fix[24:0]};
                h_den_reg <= delta_reg;
            end
        end
    end

    logic [16:0] s_q;
    logic [8:0]  deg_q;
    logic [16:0] l_d;
    logic        v_d;

    hsa_div #(.NUM_W(33), .DEN_W(18), .Q_W(17), .SIDE_W(17)) u_div_sat (
        .aclk(aclk), .aresetn(aresetn), .ce(ce), .in_valid(v_c_reg),
        .num(s_num_reg), .den(s_den_reg), .side(l_c_reg),
        .out_valid(v_d), .quot(s_q), .side_out(l_d)
    );

    hsa_div #(.NUM_W(33), .DEN_W(17), .Q_W(9), .SIDE_W(1)) u_div_hue (
        .aclk(aclk), .aresetn(aresetn), .ce(ce), .in_valid(v_c_reg),
        .num(h_num_reg), .den(h_den_reg), .side(1'b0),
        .out_valid(), .quot(deg_q), .side_out()
    );

    // ---- levels
    logic [24:0] s_prod, l_prod;
    logic [7:0]  sl_reg, ll_reg;
    logic [8:0]  deg_e_reg;
    logic        v_e_reg;

    assign s_prod = s_q * fsz;
    assign l_prod = l_d * fsz;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_e_reg <= 1'b0;
        end else if (ce) begin
            v_e_reg   <= v_d;
            sl_reg    <= s_prod[23:16];
            ll_reg    <= l_prod[23:16];
            deg_e_reg <= deg_q;
        end
    end

    // ---- gain
    logic        cpos;
    logic [9:0]  cdiff;
    logic [8:0]  cval;
    logic [15:0] sneg_prod;
    logic [15:0] p1_reg;
    logic [7:0]  sneg_reg;
    logic [8:0]  cval_reg;
    logic        cpos_reg;
    logic [7:0]  sl_f_reg, ll_f_reg;
    logic [8:0]  deg_f_reg;
    logic        v_f_reg;

    assign cpos      = gain_reg >= hsa_pkg::GAIN_UNITY;
    assign cdiff     = gain_reg - hsa_pkg::GAIN_UNITY;
    assign cval      = (cdiff > 10'(hsa_pkg::GAIN_SPAN)) ? hsa_pkg::GAIN_SPAN : cdiff[8:0];
    assign sneg_prod = sl_reg * gain_reg[7:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_f_reg <= 1'b0;
        end else if (ce) begin
            v_f_reg   <= v_e_reg;
            p1_reg    <= (fsz - sl_reg) * sl_reg;
            sneg_reg  <= sneg_prod[15:8];
            cval_reg  <= cval;
            cpos_reg  <= cpos;
            sl_f_reg  <= sl_reg;
            ll_f_reg  <= ll_reg;
            deg_f_reg <= deg_e_reg;
        end
    end

    logic [24:0] p2;
    logic [16:0] p2_reg;
    logic [33:0] side_g_reg;
    logic        v_g_reg;

    assign p2 = cval_reg * p1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_g_reg <= 1'b0;
        end else if (ce) begin
            v_g_reg    <= v_f_reg;
            p2_reg     <= p2[24:8];
            side_g_reg <= {cpos_reg, sneg_reg, sl_f_reg, ll_f_reg, deg_f_reg};
        end
    end

    logic [7:0]  gq;
    logic [33:0] side_h;
    logic        v_h;

    hsa_div #(.NUM_W(17), .DEN_W(8), .Q_W(8), .SIDE_W(34)) u_div_gain (
        .aclk(aclk), .aresetn(aresetn), .ce(ce), .in_valid(v_g_reg),
        .num(p2_reg), .den(fsz), .side(side_g_reg),
        .out_valid(v_h), .quot(gq), .side_out(side_h)
    );

    logic [7:0] sadj_reg, ll_i_reg;
    logic [8:0] deg_i_reg;
    logic       v_i_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_i_reg <= 1'b0;
        end else if (ce) begin
            v_i_reg   <= v_h;
            sadj_reg  <= side_h[33] ? side_h[24:17] + gq : side_h[32:25];
            ll_i_reg  <= side_h[16:9];
            deg_i_reg <= side_h[8:0];
        end
    end

    // ---- back to Q1.16; hue by reciprocal, carried beside the saturation divider
    logic [16:0] sq, lq, hq;
    logic        szero;
    logic        v_j;
    logic [30:0] h_prod;
    logic [17:0] sq_side;

    assign h_prod = deg_i_reg * hsa_pkg::DEG_RECIP;

    hsa_div #(.NUM_W(25), .DEN_W(8), .Q_W(17), .SIDE_W(18)) u_div_sq (
        .aclk(aclk), .aresetn(aresetn), .ce(ce), .in_valid(v_i_reg),
        .num({1'b0, sadj_reg, 16'd0}), .den(fsz), .side({h_prod[30:14], sadj_reg == 8'd0}),
        .out_valid(v_j), .quot(sq), .side_out(sq_side)
    );

    assign hq    = sq_side[17:1];
    assign szero = sq_side[0];

    hsa_div #(.NUM_W(25), .DEN_W(8), .Q_W(17), .SIDE_W(1)) u_div_lq (
        .aclk(aclk), .aresetn(aresetn), .ce(ce), .in_valid(v_i_reg),
        .num({1'b0, ll_i_reg, 16'd0}), .den(fsz), .side(1'b0),
        .out_valid(), .quot(lq), .side_out()
    );

    // ---- t2 product
    logic [17:0] mop;
    logic [34:0] t2p_reg;
    logic [16:0] lq_k_reg, sq_k_reg, h_k_reg;
    logic        szero_k_reg;
    logic        v_k_reg;

    assign mop = (lq < hsa_pkg::HALF_Q) ? {1'b0, hsa_pkg::ONE_Q} + {1'b0, sq} : {1'b0, sq};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_k_reg <= 1'b0;
        end else if (ce) begin
            v_k_reg     <= v_j;
            t2p_reg     <= lq * mop;
            lq_k_reg    <= lq;
            sq_k_reg    <= sq;
            h_k_reg     <= hq;
            szero_k_reg <= szero;
        end
    end

    // ---- t1, t2, channel positions
    logic signed [20:0] t2, t1, dd;
    logic [16:0]        tr, tb;
    logic signed [20:0] t1_l_reg, t2_l_reg;
    logic [19:0]        d_l_reg;
    logic [16:0]        pos_l_reg [3];
    logic [16:0]        lq_l_reg;
    logic               szero_l_reg;
    logic               v_l_reg;

    always_comb begin
        if (lq_k_reg < hsa_pkg::HALF_Q)
            t2 = $signed({2'b0, t2p_reg[34:16]});
        else
            t2 = $signed({4'b0, lq_k_reg}) + $signed({4'b0, sq_k_reg})
               - $signed({2'b0, t2p_reg[34:16]});
        t1 = $signed({3'b0, lq_k_reg, 1'b0}) - t2;
        dd = t2 - t1;
        tr = h_k_reg + hsa_pkg::THIRD_Q;
        if (tr > hsa_pkg::ONE_Q)
            tr = tr - hsa_pkg::ONE_Q;
        if (h_k_reg < hsa_pkg::THIRD_Q)
            tb = h_k_reg + (hsa_pkg::ONE_Q - hsa_pkg::THIRD_Q);
        else
            tb = h_k_reg - hsa_pkg::THIRD_Q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_l_reg <= 1'b0;
        end else if (ce) begin
            v_l_reg      <= v_k_reg;
            t1_l_reg     <= t1;
            t2_l_reg     <= t2;
            d_l_reg      <= (dd < 0) ? 20'd0 : dd[19:0];
            pos_l_reg[0] <= tr;
            pos_l_reg[1] <= h_k_reg;
            pos_l_reg[2] <= tb;
            lq_l_reg     <= lq_k_reg;
            szero_l_reg  <= szero_k_reg;
        end
    end

    // ---- ramp factors
    hsa_pkg::region_t   rg_m_reg [3];
    logic [15:0]        f_m_reg  [3];
    logic signed [20:0] t1_m_reg, t2_m_reg;
    logic [19:0]        d_m_reg;
    logic [16:0]        lq_m_reg;
    logic               szero_m_reg;
    logic               v_m_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_m_reg <= 1'b0;
        end else if (ce) begin
            v_m_reg     <= v_l_reg;
            t1_m_reg    <= t1_l_reg;
            t2_m_reg    <= t2_l_reg;
            d_m_reg     <= d_l_reg;
            lq_m_reg    <= lq_l_reg;
            szero_m_reg <= szero_l_reg;
            for (int i = 0; i < 3; i++) begin
                if (pos_l_reg[i] < hsa_pkg::SIXTH_Q) begin
                    rg_m_reg[i] <= hsa_pkg::RG_RISE;
                    f_m_reg[i]  <= 16'(pos_l_reg[i] * 17'd6);
                end else if (pos_l_reg[i] < hsa_pkg::HALF_Q) begin
                    rg_m_reg[i] <= hsa_pkg::RG_TOP;
                    f_m_reg[i]  <= '0;
                end else if (pos_l_reg[i] < hsa_pkg::TWO_THIRDS_Q) begin
                    rg_m_reg[i] <= hsa_pkg::RG_FALL;
                    f_m_reg[i]  <= 16'((hsa_pkg::TWO_THIRDS_Q - pos_l_reg[i]) * 17'd6);
                end else begin
                    rg_m_reg[i] <= hsa_pkg::RG_LOW;
                    f_m_reg[i]  <= '0;
                end
            end
        end
    end

    // ---- ramp products
    hsa_pkg::region_t   rg_n_reg [3];
    logic [35:0]        rp_n_reg [3];
    logic signed [20:0] t1_n_reg, t2_n_reg;
    logic [16:0]        lq_n_reg;
    logic               szero_n_reg;
    logic               v_n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_n_reg <= 1'b0;
        end else if (ce) begin
            v_n_reg     <= v_m_reg;
            t1_n_reg    <= t1_m_reg;
            t2_n_reg    <= t2_m_reg;
            lq_n_reg    <= lq_m_reg;
            szero_n_reg <= szero_m_reg;
            for (int i = 0; i < 3; i++) begin
                rg_n_reg[i] <= rg_m_reg[i];
                rp_n_reg[i] <= d_m_reg * f_m_reg[i];
            end
        end
    end

    // ---- channel value, clamped to 0..1.0
    logic signed [22:0] vr   [3];
    logic [16:0]        vc   [3];
    logic [16:0]        v_o_reg [3];
    logic               v_o_vld_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (rg_n_reg[i])
                hsa_pkg::RG_RISE,
                hsa_pkg::RG_FALL: vr[i] = 23'(t1_n_reg) + $signed({3'b0, rp_n_reg[i][35:16]});
                hsa_pkg::RG_TOP:  vr[i] = 23'(t2_n_reg);
                default:          vr[i] = 23'(t1_n_reg);
            endcase
            if (szero_n_reg)
                vc[i] = lq_n_reg;
            else if (vr[i] < 0)
                vc[i] = '0;
            else if (vr[i] > $signed({6'b0, hsa_pkg::ONE_Q}))
                vc[i] = hsa_pkg::ONE_Q;
            else
                vc[i] = vr[i][16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_o_vld_reg <= 1'b0;
        end else if (ce) begin
            v_o_vld_reg <= v_n_reg;
            for (int i = 0; i < 3; i++)
                v_o_reg[i] <= vc[i];
        end
    end

    // ---- back to channel levels, output register
    logic [24:0] out_prod [3];
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    always_comb begin
        for (int i = 0; i < 3; i++)
            out_prod[i] = v_o_reg[i] * fsz;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= v_o_vld_reg;
            m_tdata_reg  <= {out_prod[2][23:16], out_prod[1][23:16], out_prod[0][23:16]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/hsa_checker.sv =====
// Port-level checker for the HSL saturation adjust unit, bound to the top level.
// Depends on hsl_saturation_adjust_unit_defines.svh.
`default_nettype none
`include "hsl_saturation_adjust_unit_defines.svh"

module hsa_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // a held result beat keeps its data
    `HSA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // input side stalls exactly when a result is held
    `HSA_ASSERT_NOW(a_ready_link, 1'b1, s_tready == (!m_tvalid || m_tready), "s_tready does not follow output stall")

    // pipeline comes out of reset empty
    `HSA_ASSERT_NOW(a_reset_empty, $past(!aresetn), !m_tvalid, "result beat straight after reset")

endmodule

bind hsl_saturation_adjust_unit hsa_checker u_hsa_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

`default_nettype wire
